### src/rrk_pkg.sv
// Shared types, constants and the microcode program of the Rossler RK4 integrator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rrk_pkg;

  localparam int DW = 32;
  localparam int FB = 20;
  localparam int STEP_W = 21;
  localparam int PC_W = 7;
  localparam int RF_AW = 4;
  localparam int RF_DEPTH = 16;
  localparam int SRC_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int RECIP_SH = 34;

  localparam logic [DW-1:0] FX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] FX_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] FX_ONE = DW'(1) << FB;
  localparam logic [DW-1:0] RECIP6 = 32'hAAAA_AAAB;

  localparam logic [DW-1:0] RST_COEF_A = 32'd209715;
  localparam logic [DW-1:0] RST_COEF_B = 32'd209715;
  localparam logic [DW-1:0] RST_COEF_C = 32'd5976883;
  localparam logic [STEP_W-1:0] RST_STEP = 21'd10486;
  localparam logic [DW-1:0] RST_START = 32'd1048576;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd6;

  // Operand codes: below 16 a register file entry, from 16 up a fixed source.
  localparam logic [SRC_W-1:0] R_PX = 5'd0;
  localparam logic [SRC_W-1:0] R_PY = 5'd1;
  localparam logic [SRC_W-1:0] R_PZ = 5'd2;
  localparam logic [SRC_W-1:0] R_TX = 5'd3;
  localparam logic [SRC_W-1:0] R_TY = 5'd4;
  localparam logic [SRC_W-1:0] R_TZ = 5'd5;
  localparam logic [SRC_W-1:0] R_KX = 5'd6;
  localparam logic [SRC_W-1:0] R_KY = 5'd7;
  localparam logic [SRC_W-1:0] R_KZ = 5'd8;
  localparam logic [SRC_W-1:0] R_QX = 5'd9;
  localparam logic [SRC_W-1:0] R_QY = 5'd10;
  localparam logic [SRC_W-1:0] R_QZ = 5'd11;
  localparam logic [SRC_W-1:0] R_W = 5'd12;
  localparam logic [SRC_W-1:0] S_A = 5'd16;
  localparam logic [SRC_W-1:0] S_B = 5'd17;
  localparam logic [SRC_W-1:0] S_C = 5'd18;
  localparam logic [SRC_W-1:0] S_H = 5'd19;
  localparam logic [SRC_W-1:0] S_HALF = 5'd20;
  localparam logic [SRC_W-1:0] S_ZERO = 5'd21;
  localparam logic [SRC_W-1:0] S_ONE = 5'd22;
  localparam logic [SRC_W-1:0] S_X0 = 5'd23;
  localparam logic [SRC_W-1:0] S_Y0 = 5'd24;
  localparam logic [SRC_W-1:0] S_Z0 = 5'd25;

  localparam logic [PC_W-1:0] LBL_WAIT = 7'd3;
  localparam logic [PC_W-1:0] LBL_BODY = 7'd8;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MULP, OP_MULR, OP_D6P, OP_D6R, OP_MOV,
    OP_WAIT, OP_JNR, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {CAP_NONE, CAP_X, CAP_Y, CAP_Z} cap_t;

  typedef struct packed {
    op_t op;
    logic [RF_AW-1:0] dst;
    logic [SRC_W-1:0] src_a;
    logic [SRC_W-1:0] src_b;
    cap_t cap;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_t op;
    logic [RF_AW-1:0] dst;
    logic [SRC_W-1:0] src_a;
    logic [SRC_W-1:0] src_b;
    cap_t cap;
    logic rd_en;
    logic ex_en;
    logic clr_ovf;
  } ctrl_t;

  typedef struct packed {
    logic [DW-1:0] coef_a;
    logic [DW-1:0] coef_b;
    logic [DW-1:0] coef_c;
    logic [STEP_W-1:0] step_size;
    logic [DW-1:0] start_x;
    logic [DW-1:0] start_y;
    logic [DW-1:0] start_z;
  } cfg_t;

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
    logic ovf;
  } result_t;

  function automatic ucode_t dp(op_t op, logic [SRC_W-1:0] dst, logic [SRC_W-1:0] a,
                                logic [SRC_W-1:0] b, cap_t cap);
    ucode_t w;
    w.op = op;
    w.dst = dst[RF_AW-1:0];
    w.src_a = a;
    w.src_b = b;
    w.cap = cap;
    w.target = '0;
    return w;
  endfunction

  function automatic ucode_t sq(op_t op, logic [PC_W-1:0] target);
    ucode_t w;
    w.op = op;
    w.dst = '0;
    w.src_a = S_ZERO;
    w.src_b = S_ZERO;
    w.cap = CAP_NONE;
    w.target = target;
    return w;
  endfunction

  // The program: point init after reset, wait for a word, optional restart load,
  // k1..k4 with the weighted sum built as it goes, then the point update and the result emit.
  function automatic ucode_t rom_word(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      7'd0:   w = dp(OP_MOV,  R_PX, S_ONE,  S_ZERO, CAP_NONE);
      7'd1:   w = dp(OP_MOV,  R_PY, S_ONE,  S_ZERO, CAP_NONE);
      7'd2:   w = dp(OP_MOV,  R_PZ, S_ONE,  S_ZERO, CAP_NONE);
      7'd3:   w = sq(OP_WAIT, LBL_WAIT);
      7'd4:   w = sq(OP_JNR,  LBL_BODY);
      7'd5:   w = dp(OP_MOV,  R_PX, S_X0,   S_ZERO, CAP_NONE);
      7'd6:   w = dp(OP_MOV,  R_PY, S_Y0,   S_ZERO, CAP_NONE);
      7'd7:   w = dp(OP_MOV,  R_PZ, S_Z0,   S_ZERO, CAP_NONE);
      7'd8:   w = dp(OP_ADD,  R_W,  R_PY,   R_PZ,   CAP_NONE);
      7'd9:   w = dp(OP_SUB,  R_KX, S_ZERO, R_W,    CAP_NONE);
      7'd10:  w = dp(OP_MULP, R_W,  S_A,    R_PY,   CAP_NONE);
      7'd11:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd12:  w = dp(OP_ADD,  R_KY, R_PX,   R_W,    CAP_NONE);
      7'd13:  w = dp(OP_SUB,  R_W,  R_PX,   S_C,    CAP_NONE);
      7'd14:  w = dp(OP_MULP, R_W,  R_PZ,   R_W,    CAP_NONE);
      7'd15:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd16:  w = dp(OP_ADD,  R_KZ, S_B,    R_W,    CAP_NONE);
      7'd17:  w = dp(OP_MOV,  R_QX, R_KX,   S_ZERO, CAP_NONE);
      7'd18:  w = dp(OP_MOV,  R_QY, R_KY,   S_ZERO, CAP_NONE);
      7'd19:  w = dp(OP_MOV,  R_QZ, R_KZ,   S_ZERO, CAP_NONE);
      7'd20:  w = dp(OP_MULP, R_W,  S_HALF, R_KX,   CAP_NONE);
      7'd21:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd22:  w = dp(OP_ADD,  R_TX, R_PX,   R_W,    CAP_NONE);
      7'd23:  w = dp(OP_MULP, R_W,  S_HALF, R_KY,   CAP_NONE);
      7'd24:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd25:  w = dp(OP_ADD,  R_TY, R_PY,   R_W,    CAP_NONE);
      7'd26:  w = dp(OP_MULP, R_W,  S_HALF, R_KZ,   CAP_NONE);
      7'd27:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd28:  w = dp(OP_ADD,  R_TZ, R_PZ,   R_W,    CAP_NONE);
      7'd29:  w = dp(OP_ADD,  R_W,  R_TY,   R_TZ,   CAP_NONE);
      7'd30:  w = dp(OP_SUB,  R_KX, S_ZERO, R_W,    CAP_NONE);
      7'd31:  w = dp(OP_MULP, R_W,  S_A,    R_TY,   CAP_NONE);
      7'd32:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd33:  w = dp(OP_ADD,  R_KY, R_TX,   R_W,    CAP_NONE);
      7'd34:  w = dp(OP_SUB,  R_W,  R_TX,   S_C,    CAP_NONE);
      7'd35:  w = dp(OP_MULP, R_W,  R_TZ,   R_W,    CAP_NONE);
      7'd36:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd37:  w = dp(OP_ADD,  R_KZ, S_B,    R_W,    CAP_NONE);
      7'd38:  w = dp(OP_ADD,  R_QX, R_QX,   R_KX,   CAP_NONE);
      7'd39:  w = dp(OP_ADD,  R_QX, R_QX,   R_KX,   CAP_NONE);
      7'd40:  w = dp(OP_ADD,  R_QY, R_QY,   R_KY,   CAP_NONE);
      7'd41:  w = dp(OP_ADD,  R_QY, R_QY,   R_KY,   CAP_NONE);
      7'd42:  w = dp(OP_ADD,  R_QZ, R_QZ,   R_KZ,   CAP_NONE);
      7'd43:  w = dp(OP_ADD,  R_QZ, R_QZ,   R_KZ,   CAP_NONE);
      7'd44:  w = dp(OP_MULP, R_W,  S_HALF, R_KX,   CAP_NONE);
      7'd45:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd46:  w = dp(OP_ADD,  R_TX, R_PX,   R_W,    CAP_NONE);
      7'd47:  w = dp(OP_MULP, R_W,  S_HALF, R_KY,   CAP_NONE);
      7'd48:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd49:  w = dp(OP_ADD,  R_TY, R_PY,   R_W,    CAP_NONE);
      7'd50:  w = dp(OP_MULP, R_W,  S_HALF, R_KZ,   CAP_NONE);
      7'd51:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd52:  w = dp(OP_ADD,  R_TZ, R_PZ,   R_W,    CAP_NONE);
      7'd53:  w = dp(OP_ADD,  R_W,  R_TY,   R_TZ,   CAP_NONE);
      7'd54:  w = dp(OP_SUB,  R_KX, S_ZERO, R_W,    CAP_NONE);
      7'd55:  w = dp(OP_MULP, R_W,  S_A,    R_TY,   CAP_NONE);
      7'd56:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd57:  w = dp(OP_ADD,  R_KY, R_TX,   R_W,    CAP_NONE);
      7'd58:  w = dp(OP_SUB,  R_W,  R_TX,   S_C,    CAP_NONE);
      7'd59:  w = dp(OP_MULP, R_W,  R_TZ,   R_W,    CAP_NONE);
      7'd60:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd61:  w = dp(OP_ADD,  R_KZ, S_B,    R_W,    CAP_NONE);
      7'd62:  w = dp(OP_ADD,  R_QX, R_QX,   R_KX,   CAP_NONE);
      7'd63:  w = dp(OP_ADD,  R_QX, R_QX,   R_KX,   CAP_NONE);
      7'd64:  w = dp(OP_ADD,  R_QY, R_QY,   R_KY,   CAP_NONE);
      7'd65:  w = dp(OP_ADD,  R_QY, R_QY,   R_KY,   CAP_NONE);
      7'd66:  w = dp(OP_ADD,  R_QZ, R_QZ,   R_KZ,   CAP_NONE);
      7'd67:  w = dp(OP_ADD,  R_QZ, R_QZ,   R_KZ,   CAP_NONE);
      7'd68:  w = dp(OP_MULP, R_W,  S_H,    R_KX,   CAP_NONE);
      7'd69:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd70:  w = dp(OP_ADD,  R_TX, R_PX,   R_W,    CAP_NONE);
      7'd71:  w = dp(OP_MULP, R_W,  S_H,    R_KY,   CAP_NONE);
      7'd72:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd73:  w = dp(OP_ADD,  R_TY, R_PY,   R_W,    CAP_NONE);
      7'd74:  w = dp(OP_MULP, R_W,  S_H,    R_KZ,   CAP_NONE);
      7'd75:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd76:  w = dp(OP_ADD,  R_TZ, R_PZ,   R_W,    CAP_NONE);
      7'd77:  w = dp(OP_ADD,  R_W,  R_TY,   R_TZ,   CAP_NONE);
      7'd78:  w = dp(OP_SUB,  R_KX, S_ZERO, R_W,    CAP_NONE);
      7'd79:  w = dp(OP_MULP, R_W,  S_A,    R_TY,   CAP_NONE);
      7'd80:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd81:  w = dp(OP_ADD,  R_KY, R_TX,   R_W,    CAP_NONE);
      7'd82:  w = dp(OP_SUB,  R_W,  R_TX,   S_C,    CAP_NONE);
      7'd83:  w = dp(OP_MULP, R_W,  R_TZ,   R_W,    CAP_NONE);
      7'd84:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd85:  w = dp(OP_ADD,  R_KZ, S_B,    R_W,    CAP_NONE);
      7'd86:  w = dp(OP_ADD,  R_QX, R_QX,   R_KX,   CAP_NONE);
      7'd87:  w = dp(OP_ADD,  R_QY, R_QY,   R_KY,   CAP_NONE);
      7'd88:  w = dp(OP_ADD,  R_QZ, R_QZ,   R_KZ,   CAP_NONE);
      7'd89:  w = dp(OP_MULP, R_W,  S_H,    R_QX,   CAP_NONE);
      7'd90:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd91:  w = dp(OP_D6P,  R_W,  R_W,    S_ZERO, CAP_NONE);
      7'd92:  w = dp(OP_D6R,  R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd93:  w = dp(OP_ADD,  R_PX, R_PX,   R_W,    CAP_X);
      7'd94:  w = dp(OP_MULP, R_W,  S_H,    R_QY,   CAP_NONE);
      7'd95:  w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd96:  w = dp(OP_D6P,  R_W,  R_W,    S_ZERO, CAP_NONE);
      7'd97:  w = dp(OP_D6R,  R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd98:  w = dp(OP_ADD,  R_PY, R_PY,   R_W,    CAP_Y);
      7'd99:  w = dp(OP_MULP, R_W,  S_H,    R_QZ,   CAP_NONE);
      7'd100: w = dp(OP_MULR, R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd101: w = dp(OP_D6P,  R_W,  R_W,    S_ZERO, CAP_NONE);
      7'd102: w = dp(OP_D6R,  R_W,  S_ZERO, S_ZERO, CAP_NONE);
      7'd103: w = dp(OP_ADD,  R_PZ, R_PZ,   R_W,    CAP_Z);
      7'd104: w = sq(OP_EMIT, LBL_WAIT);
      default: w = sq(OP_WAIT, LBL_WAIT);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/rrk_sequencer.sv
// Microcode sequencer: step counter over the program in rrk_pkg, handshakes and result register.
// Depends on rrk_pkg; drives rrk_datapath through an rrk_pkg::ctrl_t word.
`default_nettype none

module rrk_sequencer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic                       restart,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [3*rrk_pkg::DW-1:0]        m_tdata,
  output logic [0:0]                      m_tuser,
  input  wire rrk_pkg::result_t           res,
  output rrk_pkg::ctrl_t                  ctrl
);

  typedef enum logic {PH_READ, PH_EXEC} phase_t;

  logic [rrk_pkg::PC_W-1:0] pc;
  phase_t                   phase;
  logic                     restart_q;
  rrk_pkg::ucode_t          word;
  logic                     dp_op;
  logic                     emit_go;

  always_comb begin
    word = rrk_pkg::rom_word(pc);
    dp_op = (word.op != rrk_pkg::OP_WAIT) && (word.op != rrk_pkg::OP_JNR) &&
            (word.op != rrk_pkg::OP_EMIT);
    emit_go = (word.op == rrk_pkg::OP_EMIT) && (!m_tvalid || m_tready);
    s_tready = (word.op == rrk_pkg::OP_WAIT);
    ctrl.op = word.op;
    ctrl.dst = word.dst;
    ctrl.src_a = word.src_a;
    ctrl.src_b = word.src_b;
    ctrl.cap = word.cap;
    ctrl.rd_en = dp_op && (phase == PH_READ);
    ctrl.ex_en = dp_op && (phase == PH_EXEC);
    ctrl.clr_ovf = s_tready && s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      phase <= PH_READ;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (word.op)
        rrk_pkg::OP_WAIT: begin
          if (s_tvalid) begin
            restart_q <= restart;
            pc <= pc + rrk_pkg::PC_W'(1);
          end
        end
        rrk_pkg::OP_JNR: begin
          pc <= restart_q ? pc + rrk_pkg::PC_W'(1) : word.target;
        end
        rrk_pkg::OP_EMIT: begin
          if (emit_go) begin
            m_tdata <= {res.z, res.y, res.x};
            m_tuser <= res.ovf;
            pc <= word.target;
          end
        end
        default: begin
          if (phase == PH_READ) begin
            phase <= PH_EXEC;
          end else begin
            phase <= PH_READ;
            pc <= pc + rrk_pkg::PC_W'(1);
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/rrk_datapath.sv
// Datapath: register file memory, saturating add/sub, shared multiplier for
// rounded products and division by six, overflow flag and result capture.
// Depends on rrk_pkg; controlled by rrk_sequencer.
`default_nettype none

module rrk_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rrk_pkg::ctrl_t   ctrl,
  input  wire rrk_pkg::cfg_t    cfg,
  output rrk_pkg::result_t      res
);

  localparam int DW = rrk_pkg::DW;
  localparam int FB = rrk_pkg::FB;
  localparam int QW = 2 * DW - FB;
  localparam int DQW = 2 * DW - rrk_pkg::RECIP_SH;

  logic [DW-1:0]   rf [rrk_pkg::RF_DEPTH];
  logic [DW-1:0]   rd_a, rd_b;
  logic [DW-1:0]   opa, opb;
  logic [DW:0]     sum_ext;
  logic [DW-1:0]   mag_a, mag_b, bias_a;
  logic [DW-1:0]   mul_a, mul_b;
  logic [2*DW-1:0] prod;
  logic [2*DW-1:0] preg;
  logic            pneg;
  logic [2*DW-1:0] rnd;
  logic [QW-1:0]   q;
  logic [QW-1:0]   qlim;
  logic [DQW-1:0]  q6;
  logic [DW-1:0]   alu_res;
  logic            alu_sat;
  logic            wr_en;
  logic            ovf;
  logic [DW-1:0]   res_x, res_y, res_z;

  function automatic logic [DW-1:0] fixed_src(logic [rrk_pkg::SRC_W-1:0] code,
                                               rrk_pkg::cfg_t c);
    logic [DW-1:0] v;
    unique case (code)
      rrk_pkg::S_A:    v = c.coef_a;
      rrk_pkg::S_B:    v = c.coef_b;
      rrk_pkg::S_C:    v = c.coef_c;
      rrk_pkg::S_H:    v = DW'(c.step_size);
      rrk_pkg::S_HALF: v = DW'(c.step_size >> 1);
      rrk_pkg::S_ONE:  v = rrk_pkg::FX_ONE;
      rrk_pkg::S_X0:   v = c.start_x;
      rrk_pkg::S_Y0:   v = c.start_y;
      rrk_pkg::S_Z0:   v = c.start_z;
      default:         v = '0;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_a <= rf[ctrl.src_a[rrk_pkg::RF_AW-1:0]];
      rd_b <= rf[ctrl.src_b[rrk_pkg::RF_AW-1:0]];
    end
    if (ctrl.ex_en && wr_en) begin
      rf[ctrl.dst] <= alu_res;
    end
  end

  always_comb begin
    opa = ctrl.src_a[rrk_pkg::SRC_W-1] ? fixed_src(ctrl.src_a, cfg) : rd_a;
    opb = ctrl.src_b[rrk_pkg::SRC_W-1] ? fixed_src(ctrl.src_b, cfg) : rd_b;
    mag_a = opa[DW-1] ? DW'(-opa) : opa;
    mag_b = opb[DW-1] ? DW'(-opb) : opb;
    bias_a = mag_a + DW'(3);
    if (ctrl.op == rrk_pkg::OP_D6P) begin
      mul_a = bias_a;
      mul_b = rrk_pkg::RECIP6;
    end else begin
      mul_a = mag_a;
      mul_b = mag_b;
    end
    prod = mul_a * mul_b;
    if (ctrl.op == rrk_pkg::OP_SUB) begin
      sum_ext = {opa[DW-1], opa} - {opb[DW-1], opb};
    end else begin
      sum_ext = {opa[DW-1], opa} + {opb[DW-1], opb};
    end
    rnd = preg + ((2*DW)'(1) << (FB - 1));
    q = rnd[2*DW-1:FB];
    qlim = pneg ? QW'(rrk_pkg::FX_MIN) : QW'(rrk_pkg::FX_MAX);
    q6 = preg[2*DW-1:rrk_pkg::RECIP_SH];
    alu_res = '0;
    alu_sat = 1'b0;
    wr_en = 1'b0;
    unique case (ctrl.op)
      rrk_pkg::OP_ADD, rrk_pkg::OP_SUB: begin
        wr_en = 1'b1;
        if (sum_ext[DW] != sum_ext[DW-1]) begin
          alu_sat = 1'b1;
          alu_res = sum_ext[DW] ? rrk_pkg::FX_MIN : rrk_pkg::FX_MAX;
        end else begin
          alu_res = sum_ext[DW-1:0];
        end
      end
      rrk_pkg::OP_MULR: begin
        wr_en = 1'b1;
        if (q > qlim) begin
          alu_sat = 1'b1;
          alu_res = pneg ? rrk_pkg::FX_MIN : rrk_pkg::FX_MAX;
        end else begin
          alu_res = pneg ? DW'(-q[DW-1:0]) : q[DW-1:0];
        end
      end
      rrk_pkg::OP_D6R: begin
        wr_en = 1'b1;
        alu_res = pneg ? DW'(-DW'(q6)) : DW'(q6);
      end
      rrk_pkg::OP_MOV: begin
        wr_en = 1'b1;
        alu_res = opa;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else begin
      if (ctrl.clr_ovf) begin
        ovf <= 1'b0;
      end else if (ctrl.ex_en && alu_sat) begin
        ovf <= 1'b1;
      end
    end
    if (ctrl.ex_en && (ctrl.op == rrk_pkg::OP_MULP || ctrl.op == rrk_pkg::OP_D6P)) begin
      preg <= prod;
      pneg <= (ctrl.op == rrk_pkg::OP_D6P) ? opa[DW-1] : (opa[DW-1] ^ opb[DW-1]);
    end
    if (ctrl.ex_en) begin
      unique case (ctrl.cap)
        rrk_pkg::CAP_X: res_x <= alu_res;
        rrk_pkg::CAP_Y: res_y <= alu_res;
        rrk_pkg::CAP_Z: res_z <= alu_res;
        default: begin
        end
      endcase
    end
  end

  assign res.x = res_x;
  assign res.y = res_y;
  assign res.z = res_z;
  assign res.ovf = ovf;

endmodule

`default_nettype wire

### src/rk4_rossler_integrator_unit.sv
// Top level of the Rossler RK4 integrator: configuration registers, sequencer and datapath.
// Depends on rrk_pkg, rrk_sequencer and rrk_datapath.
//
//   channel  direction  signals                              word
//   s_*      in         s_tvalid s_tready s_tdata[7:0]       bit 0 restart
//   m_*      out        m_tvalid m_tready m_tdata m_tuser    point x, y, z; overflow
//   cfg_*    in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// One step runs 96 datapath micro-ops from input accept to the result register, plus the start
// point load with restart; each micro-op is a register file read, then an execute.
// After reset an init program writes the point to 1.0 before s_tready rises.
// A finished result waits in the output register while the next word is accepted.
// Configuration writes are taken every cycle.
`default_nettype none

module rk4_rossler_integrator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // [0] restart
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [3*rrk_pkg::DW-1:0]               m_tdata,   // [31:0] point_x, [63:32] point_y,
                                                            // [95:64] point_z
  output logic [0:0]                             m_tuser,   // [0] overflow
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rrk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rrk_pkg::DW-1:0]            cfg_data
);

  rrk_pkg::cfg_t    cfg;
  rrk_pkg::ctrl_t   ctrl;
  rrk_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_a <= rrk_pkg::RST_COEF_A;
      cfg.coef_b <= rrk_pkg::RST_COEF_B;
      cfg.coef_c <= rrk_pkg::RST_COEF_C;
      cfg.step_size <= rrk_pkg::RST_STEP;
      cfg.start_x <= rrk_pkg::RST_START;
      cfg.start_y <= rrk_pkg::RST_START;
      cfg.start_z <= rrk_pkg::RST_START;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rrk_pkg::CFG_COEF_A:  cfg.coef_a <= cfg_data;
        rrk_pkg::CFG_COEF_B:  cfg.coef_b <= cfg_data;
        rrk_pkg::CFG_COEF_C:  cfg.coef_c <= cfg_data;
        rrk_pkg::CFG_STEP:    cfg.step_size <= cfg_data[rrk_pkg::STEP_W-1:0];
        rrk_pkg::CFG_START_X: cfg.start_x <= cfg_data;
        rrk_pkg::CFG_START_Y: cfg.start_y <= cfg_data;
        rrk_pkg::CFG_START_Z: cfg.start_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rrk_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .restart  (s_tdata[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .res      (res),
    .ctrl     (ctrl)
  );

  rrk_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .cfg  (cfg),
    .res  (res)
  );

endmodule

`default_nettype wire

### src/rrk_checker.sv
// Port-level checks of the Rossler RK4 integrator and their bind to the top level.
// Depends on rrk_pkg and rk4_rossler_integrator_unit.
`default_nettype none

module rrk_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [3*rrk_pkg::DW-1:0]      m_tdata,
  input wire logic [0:0]                    m_tuser
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // The point init program runs after reset, so no word is taken right away.
  a_init_busy: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during point init");

  // Once a word is accepted the block is busy on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // A new result appears only at the end of a step, never while waiting for input.
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result raised while waiting for input");

endmodule

bind rk4_rossler_integrator_unit rrk_checker u_chk (.*);

`default_nettype wire
